### hw/rtl/trps_pkg.sv
package trps_pkg;

  // Field widths
  localparam int POS_W = 16;
  localparam int TAG_W = 8;
  localparam int CFG_W = 5;

  // Defaults
  localparam int              MAX_TARGETS_DEF = 16;
  localparam logic [CFG_W-1:0] FRS_RESET      = 5'd4;

  // Stored object record
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [TAG_W-1:0]        tag;
  } rec_t;

  // Ordered result entry
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             row;
  } res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,   // taking objects
    ST_RDI,    // read outer object
    ST_LATI,   // latch outer object
    ST_CMP,    // compare inner object
    ST_RDJ,    // read next inner object
    ST_WR,     // write rank or ordered entry
    ST_ORD,    // read ordered entry
    ST_OLD     // load output register
  } state_t;

  // Signed to offset binary so that an unsigned compare orders correctly
  function automatic logic [POS_W-1:0] ofs(input logic signed [POS_W-1:0] v);
    ofs = {~v[POS_W-1], v[POS_W-2:0]};
  endfunction

endpackage

### hw/rtl/trps_in_if.sv
interface trps_in_if;
  import trps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [TAG_W-1:0]        object_tag;
  logic                    set_end;

  modport source (output valid, pos_x, pos_y, object_tag, set_end, input ready);
  modport sink   (input valid, pos_x, pos_y, object_tag, set_end, output ready);
endinterface

### hw/rtl/trps_out_if.sv
interface trps_out_if;
  import trps_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] sorted_tag;
  logic             row_index;
  logic             overflowed;
  logic             final_result;

  modport source (output valid, sorted_tag, row_index, overflowed, final_result, input ready);
  modport sink   (input valid, sorted_tag, row_index, overflowed, final_result, output ready);
endinterface

### hw/rtl/two_row_position_sorter_top.sv
// Loading: one object transaction per cycle while no sort or result readout is running.
// Sort after the set_end transaction: two ranking passes over one shared key comparator
// for the n stored objects, first by y, then by x within each row.
// Output: n results per set, read in order from the ordered-result memory.
// Reset (rst_n low, synchronous): sequencer to load, object count and overflow cleared,
// first_row_size back to 4; the object stores are not cleared.
module two_row_position_sorter_top #(
  parameter int MAX_TARGETS = trps_pkg::MAX_TARGETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  trps_in_if.sink                    in_ch,
  trps_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [trps_pkg::CFG_W-1:0] cfg_wdata
);
  import trps_pkg::*;

  localparam int IW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CW   = $clog2(MAX_TARGETS + 1);
  localparam int SW   = (CW > CFG_W) ? CW : CFG_W;
  localparam int KEYW = 2 * POS_W + IW;

  // Control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r;
  logic             ovf_r;
  logic [CFG_W-1:0] frs_r;
  logic             phase_r;     // 0: rank by y, 1: rank by x within row
  logic [CW-1:0]    split_r;
  logic [IW-1:0]    i_r, j_r, e_r;
  logic [IW-1:0]    cnt_r;
  logic             out_valid_r;

  // Latched outer object
  logic [POS_W-1:0] xi_r, yi_r;
  logic [TAG_W-1:0] tagi_r;
  logic             rowi_r;

  // Output payload
  logic [TAG_W-1:0] sorted_tag_r;
  logic             row_index_r, overflowed_r, final_result_r;

  // Memories
  rec_t          rec_mem  [MAX_TARGETS];
  logic [IW-1:0] rank_mem [MAX_TARGETS];
  res_t          res_mem  [MAX_TARGETS];
  rec_t          rec_q;
  logic [IW-1:0] rank_q;
  res_t          res_q;

  // Decoded control
  logic          in_fire, slot_free, out_load;
  logic          last_j, last_i, last_e, has_room;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] n_new;
  logic [SW-1:0] split_sel;
  logic [KEYW-1:0] key_i, key_j;
  logic          less;
  logic [CW-1:0] pos;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign has_room  = count_r < CW'(MAX_TARGETS);
  assign last_j    = (CW'(j_r) + CW'(1)) == count_r;
  assign last_i    = (CW'(i_r) + CW'(1)) == count_r;
  assign last_e    = (CW'(e_r) + CW'(1)) == count_r;

  // Set size and row split at set end, split saturated to the count
  assign n_new     = has_room ? count_r + CW'(1) : count_r;
  assign split_sel = (SW'(frs_r) < SW'(n_new)) ? SW'(frs_r) : SW'(n_new);

  // Shared key comparator: (y, index) in pass 0, (x, y, index) in pass 1
  assign key_i = phase_r ? {ofs(xi_r), ofs(yi_r), i_r} : {ofs(yi_r), {POS_W{1'b0}}, i_r};
  assign key_j = phase_r ? {ofs(rec_q.x), ofs(rec_q.y), j_r}
                         : {ofs(rec_q.y), {POS_W{1'b0}}, j_r};
  assign less  = (key_j < key_i) &&
                 (!phase_r || ((CW'(rank_q) >= split_r) == rowi_r));

  // Place in the final list
  assign pos = CW'(cnt_r) + (rowi_r ? split_r : CW'(0));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_fire && in_ch.set_end) state_nxt = ST_RDI;
      ST_RDI:  state_nxt = ST_LATI;
      ST_LATI: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = last_j ? ST_WR : ST_RDJ;
      ST_RDJ:  state_nxt = ST_CMP;
      ST_WR: begin
        if (last_i && phase_r) state_nxt = ST_ORD;
        else                   state_nxt = ST_RDI;
      end
      ST_ORD:  state_nxt = ST_OLD;
      ST_OLD: begin
        if (slot_free) state_nxt = last_e ? ST_LOAD : ST_ORD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    rd_addr     = j_r;
    case (state_r)
      ST_LOAD: in_ch.ready = 1'b1;
      ST_RDI:  rd_addr     = i_r;
      ST_OLD:  out_load    = slot_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      frs_r       <= FRS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) frs_r <= cfg_wdata;
      if (in_fire) begin
        if (has_room) count_r <= count_r + CW'(1);
        else          ovf_r   <= 1'b1;
      end
      if (out_load && last_e) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        if (in_fire && in_ch.set_end) begin
          split_r <= split_sel[CW-1:0];
          phase_r <= 1'b0;
          i_r     <= '0;
        end
      end
      ST_RDI: j_r <= '0;
      ST_LATI: begin
        xi_r   <= rec_q.x;
        yi_r   <= rec_q.y;
        tagi_r <= rec_q.tag;
        rowi_r <= CW'(rank_q) >= split_r;
        cnt_r  <= '0;
      end
      ST_CMP: begin
        if (less)    cnt_r <= cnt_r + IW'(1);
        if (!last_j) j_r   <= j_r + IW'(1);
      end
      ST_WR: begin
        if (last_i) begin
          i_r     <= '0;
          phase_r <= 1'b1;
          e_r     <= '0;
        end else begin
          i_r <= i_r + IW'(1);
        end
      end
      ST_OLD: begin
        if (out_load) begin
          sorted_tag_r   <= res_q.tag;
          row_index_r    <= res_q.row;
          overflowed_r   <= ovf_r;
          final_result_r <= last_e;
          if (!last_e) e_r <= e_r + IW'(1);
        end
      end
      default: ;
    endcase
  end

  // Object, rank and result memories with registered reads
  always_ff @(posedge clk) begin
    if (in_fire && has_room)
      rec_mem[count_r[IW-1:0]] <= '{x: in_ch.pos_x, y: in_ch.pos_y, tag: in_ch.object_tag};
    if (state_r == ST_WR && !phase_r) rank_mem[i_r] <= cnt_r;
    if (state_r == ST_WR && phase_r)  res_mem[pos[IW-1:0]] <= '{tag: tagi_r, row: rowi_r};
    rec_q  <= rec_mem[rd_addr];
    rank_q <= rank_mem[rd_addr];
    res_q  <= res_mem[e_r];
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_tag   = sorted_tag_r;
  assign out_ch.row_index    = row_index_r;
  assign out_ch.overflowed   = overflowed_r;
  assign out_ch.final_result = final_result_r;

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TARGETS))
    else $error("object count beyond capacity");

  a_split_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> (split_r <= count_r))
    else $error("row split beyond object count");

  a_rank_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (cnt_r <= j_r))
    else $error("rank count ahead of inner index");

  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR && phase_r) |-> (pos < count_r))
    else $error("ordered position outside the set");

  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && last_e) |=> (count_r == '0 && !ovf_r && state_r == ST_LOAD))
    else $error("set state not cleared after final result");

endmodule

### bench/two_row_position_sorter_top_test.sv
`timescale 1ns / 1ps

module two_row_position_sorter_top_test;
  import trps_pkg::*;

  localparam int N_SLOTS     = MAX_TARGETS_DEF;
  localparam int MAX_REPORTS = 10;

  // One object as offered on the input channel
  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [TAG_W-1:0]        tag;
    logic                    last;
  } object_t;

  // One expected entry of the ordered tag list
  typedef struct {
    logic [TAG_W-1:0] tag;
    logic             row;
    logic             dropped;
    logic             last;
  } ranked_tag_t;

  typedef enum int {FILL_WIDE, FILL_TIED, FILL_EDGE} fill_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  trps_in_if  in_ch();
  trps_out_if out_ch();

  two_row_position_sorter_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block: held objects, row split and the ordered tags still due
  rec_t        held_obj[N_SLOTS];
  int          slot_rank[N_SLOTS];
  int          held_count   = 0;
  bit          held_dropped = 1'b0;
  int          row0_size    = int'(FRS_RESET);
  ranked_tag_t ranked_q[$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int mismatches      = 0;
  int results_seen    = 0;
  int sets_done       = 0;
  int objects_sent    = 0;
  int dropped_objects = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Position key of a held slot, x or y
  function automatic logic signed [POS_W-1:0] slot_key(input int s, input bit by_x);
    return by_x ? held_obj[s].x : held_obj[s].y;
  endfunction

  // Stable insertion sort of slot_rank[lo..hi) by ascending key
  function automatic void order_span(input int lo, input int hi, input bit by_x);
    int cur;
    int j;
    for (int i = lo + 1; i < hi; i++) begin
      cur = slot_rank[i];
      j   = i;
      while (j > lo && slot_key(slot_rank[j-1], by_x) > slot_key(cur, by_x)) begin
        slot_rank[j] = slot_rank[j-1];
        j--;
      end
      slot_rank[j] = cur;
    end
  endfunction

  function automatic object_t make_obj(input logic signed [POS_W-1:0] x,
                                       input logic signed [POS_W-1:0] y,
                                       input logic [TAG_W-1:0] tag, input logic last);
    object_t o;
    o.x    = x;
    o.y    = y;
    o.tag  = tag;
    o.last = last;
    return o;
  endfunction

  function automatic logic signed [POS_W-1:0] pick_pos(input fill_mode_t mode);
    case (mode)
      FILL_TIED: return POS_W'($urandom_range(0, 4)) - 16'sd2;
      FILL_EDGE: begin
        case ($urandom_range(0, 4))
          0:       return -16'sd32768;
          1:       return -16'sd1;
          2:       return 16'sd0;
          3:       return 16'sd1;
          default: return 16'sd32767;
        endcase
      end
      default:   return POS_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one object, wait for its transaction, then update the shadow
  task automatic send_object(input object_t o);
    int          split;
    ranked_tag_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pos_x      <= o.x;
    in_ch.pos_y      <= o.y;
    in_ch.object_tag <= o.tag;
    in_ch.set_end    <= o.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    objects_sent++;

    // store, or drop and flag once full
    if (held_count < N_SLOTS) begin
      held_obj[held_count].x   = o.x;
      held_obj[held_count].y   = o.y;
      held_obj[held_count].tag = o.tag;
      held_count++;
    end else begin
      held_dropped = 1'b1;
      dropped_objects++;
    end

    // end of set: order by y, split into rows, order each row by x
    if (o.last) begin
      for (int k = 0; k < held_count; k++) slot_rank[k] = k;
      order_span(0, held_count, 1'b0);
      split = (row0_size < held_count) ? row0_size : held_count;
      order_span(0, split, 1'b1);
      order_span(split, held_count, 1'b1);
      for (int k = 0; k < held_count; k++) begin
        r.tag     = held_obj[slot_rank[k]].tag;
        r.row     = (k >= split);
        r.dropped = held_dropped;
        r.last    = (k + 1 == held_count);
        ranked_q  = {ranked_q, r};
      end
      held_count   = 0;
      held_dropped = 1'b0;
      sets_done++;
    end
  endtask

  task automatic send_set(input int n, input fill_mode_t mode);
    for (int k = 0; k < n; k++)
      send_object(make_obj(pick_pos(mode), pick_pos(mode),
                           TAG_W'($urandom_range(0, 255)), k == n - 1));
  endtask

  // Stop offering and let every due tag come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_row_size(input int v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    row0_size = v;
  endtask

  // Reset row size of 4, extreme positions, ties on y and on both keys
  task automatic test_reset_row_size();
    send_object(make_obj(16'sd32767, 16'sd0, 8'hFF, 1'b0));
    send_object(make_obj(-16'sd32768, 16'sd0, 8'h00, 1'b0));
    send_object(make_obj(16'sd0, -16'sd32768, 8'h55, 1'b0));
    send_object(make_obj(-16'sd1, 16'sd32767, 8'hAA, 1'b0));
    send_object(make_obj(-16'sd1, 16'sd32767, 8'h01, 1'b1));
  endtask

  // Row size zero: everything lands in row 1
  task automatic test_row_size_zero();
    write_row_size(0);
    send_object(make_obj(16'sd7, -16'sd7, 8'h3C, 1'b1));
  endtask

  // Row size beyond the object count saturates
  task automatic test_row_size_beyond();
    write_row_size(31);
    send_object(make_obj(16'sd100, 16'sd5, 8'h0F, 1'b0));
    send_object(make_obj(-16'sd100, 16'sd5, 8'hF0, 1'b1));
  endtask

  // Full store: the set_end object itself is dropped, the set still ends
  task automatic test_store_full();
    write_row_size(16);
    send_set(N_SLOTS + 1, FILL_TIED);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int item_budget);
    int done_items;
    int n;
    int r;
    done_items      = 0;
    send_idle_pct   = idle_pct;
    recv_stall_pct  = stall_pct;
    while (done_items < item_budget) begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 2))
            0:       write_row_size(0);
            1:       write_row_size(16);
            default: write_row_size(31);
          endcase
        end else begin
          write_row_size($urandom_range(0, 31));
        end
      end
      // mostly small sets, some larger ones up to capacity, a few past capacity
      r = $urandom_range(0, 99);
      if (r < 65)      n = $urandom_range(1, 6);
      else if (r < 90) n = $urandom_range(7, N_SLOTS);
      else             n = $urandom_range(N_SLOTS + 1, N_SLOTS + 3);
      send_set(n, fill_mode_t'($urandom_range(0, 2)));
      done_items += n;
    end
  endtask

  // Stimulus sequence
  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.pos_x      <= '0;
    in_ch.pos_y      <= '0;
    in_ch.object_tag <= '0;
    in_ch.set_end    <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_row_size();
    test_row_size_zero();
    test_row_size_beyond();
    test_store_full();
    test_random_traffic(0, 0, 82);
    test_random_traffic(72, 0, 82);
    test_random_traffic(0, 72, 82);
    test_random_traffic(11, 11, 82);

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d objects in %0d sets, %0d dropped at capacity;", objects_sent,
             sets_done, dropped_objects);
    $display("%0d ordered tags checked, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS two_row_position_sorter_top");
    end else begin
      $display("FAIL two_row_position_sorter_top");
    end
    $finish;
  end

  // Result side: random stalls, each transaction checked against the oldest due tag
  initial begin
    ranked_tag_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (ranked_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%t: unexpected result tag %02h row %0d ovf %0d final %0d", $realtime,
                     out_ch.sorted_tag, out_ch.row_index, out_ch.overflowed,
                     out_ch.final_result);
        end else begin
          want = ranked_q.pop_front();
          if (out_ch.sorted_tag !== want.tag || out_ch.row_index !== want.row ||
              out_ch.overflowed !== want.dropped || out_ch.final_result !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%t: expected tag %02h row %0d ovf %0d final %0d, got %02h %0d %0d %0d",
                       $realtime, want.tag, want.row, want.dropped, want.last,
                       out_ch.sorted_tag, out_ch.row_index, out_ch.overflowed,
                       out_ch.final_result);
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL two_row_position_sorter_top");
    $finish;
  end

endmodule

### files.f
hw/rtl/trps_pkg.sv
hw/rtl/trps_in_if.sv
hw/rtl/trps_out_if.sv
hw/rtl/two_row_position_sorter_top.sv
bench/two_row_position_sorter_top_test.sv
